[hw/rtl/alle_pkg.sv]
// Shared types, codes and widths of the array linked list engine.
`timescale 1ns / 1ps

package alle_pkg;

    localparam int SLOTS_DEFAULT = 256;
    localparam int SLOTS_MAX     = 65536;
    localparam int LINK_MAX_W    = $clog2(SLOTS_MAX);

    localparam int ACTION_W = 4;
    localparam int SLOT_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 8;

    localparam int IN_TDATA_W  = ((SLOT_W + VALUE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SLOT_W + VALUE_W + COUNT_W + 7) / 8) * 8;

    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT   = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK    = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT    = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK     = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_INSERT_AFTER = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_REMOVE       = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_SET          = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_GET          = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_NEXT         = 4'd8;
    localparam logic [ACTION_W-1:0] ACT_PREV         = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_FRONT        = 4'd10;
    localparam logic [ACTION_W-1:0] ACT_BACK         = 4'd11;

    localparam logic [STATUS_W-1:0] STAT_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_HEAD  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 3'd4;

    // Access request from the sequencer to the slot table
    typedef struct packed {
        logic                      rd_en;
        logic [LINK_MAX_W-1:0]     nxt_rd_addr;
        logic [LINK_MAX_W-1:0]     prv_rd_addr;
        logic [LINK_MAX_W-1:0]     slot_rd_addr;
        logic                      nxt_wr_en;
        logic [LINK_MAX_W-1:0]     nxt_wr_addr;
        logic [LINK_MAX_W-1:0]     nxt_wr_data;
        logic                      prv_wr_en;
        logic [LINK_MAX_W-1:0]     prv_wr_addr;
        logic [LINK_MAX_W-1:0]     prv_wr_data;
        logic                      used_wr_en;
        logic [LINK_MAX_W-1:0]     used_wr_addr;
        logic                      used_wr_data;
        logic                      elem_wr_en;
        logic [LINK_MAX_W-1:0]     elem_wr_addr;
        logic [VALUE_W-1:0]        elem_wr_data;
    } tbl_req_t;

    // Registered read data of the slot table
    typedef struct packed {
        logic [LINK_MAX_W-1:0] nxt_rd_data;
        logic [LINK_MAX_W-1:0] prv_rd_data;
        logic                  used_rd_data;
        logic [VALUE_W-1:0]    elem_rd_data;
    } tbl_rsp_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [SLOT_W-1:0]         index_out;
        logic signed [VALUE_W-1:0] value_out;
        logic [COUNT_W-1:0]        count;
    } res_t;

    function automatic logic is_unlink(input logic [ACTION_W-1:0] act);
        return (act == ACT_POP_FRONT) || (act == ACT_POP_BACK) || (act == ACT_REMOVE);
    endfunction

endpackage

[hw/rtl/alle_table.sv]
// Slot table: next, prev, used and element memories, one read and one write port each.
`timescale 1ns / 1ps

module alle_table #(
    parameter int SLOTS = alle_pkg::SLOTS_DEFAULT
) (
    input  logic               clk,
    input  alle_pkg::tbl_req_t req,
    output alle_pkg::tbl_rsp_t rsp
);
    import alle_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    logic [IDX_W-1:0]   nxt_mem  [SLOTS];
    logic [IDX_W-1:0]   prv_mem  [SLOTS];
    logic               used_mem [SLOTS];
    logic [VALUE_W-1:0] elem_mem [SLOTS];

    logic [IDX_W-1:0]   nxt_q_reg;
    logic [IDX_W-1:0]   prv_q_reg;
    logic               used_q_reg;
    logic [VALUE_W-1:0] elem_q_reg;

    always_ff @(posedge clk)
    begin
        if (req.nxt_wr_en)
        begin
            nxt_mem[req.nxt_wr_addr[IDX_W-1:0]] <= req.nxt_wr_data[IDX_W-1:0];
        end
        if (req.rd_en)
        begin
            nxt_q_reg <= nxt_mem[req.nxt_rd_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.prv_wr_en)
        begin
            prv_mem[req.prv_wr_addr[IDX_W-1:0]] <= req.prv_wr_data[IDX_W-1:0];
        end
        if (req.rd_en)
        begin
            prv_q_reg <= prv_mem[req.prv_rd_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.used_wr_en)
        begin
            used_mem[req.used_wr_addr[IDX_W-1:0]] <= req.used_wr_data;
        end
        if (req.rd_en)
        begin
            used_q_reg <= used_mem[req.slot_rd_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.elem_wr_en)
        begin
            elem_mem[req.elem_wr_addr[IDX_W-1:0]] <= req.elem_wr_data;
        end
        if (req.rd_en)
        begin
            elem_q_reg <= elem_mem[req.slot_rd_addr[IDX_W-1:0]];
        end
    end

    assign rsp.nxt_rd_data  = LINK_MAX_W'(nxt_q_reg);
    assign rsp.prv_rd_data  = LINK_MAX_W'(prv_q_reg);
    assign rsp.used_rd_data = used_q_reg;
    assign rsp.elem_rd_data = elem_q_reg;

endmodule

[hw/rtl/alle_seq.sv]
// Sequencer: clearing pass, request decode, link reads and link rewrites over the slot table.
`timescale 1ns / 1ps

module alle_seq #(
    parameter int SLOTS = alle_pkg::SLOTS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [alle_pkg::ACTION_W-1:0]        action,
    input  logic [alle_pkg::SLOT_W-1:0]          slot_index,
    input  logic signed [alle_pkg::VALUE_W-1:0]  value_in,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output alle_pkg::res_t                       res,
    output alle_pkg::tbl_req_t                   req,
    input  alle_pkg::tbl_rsp_t                   rsp
);
    import alle_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RDA   = 3'd2;
    localparam logic [2:0] S_RDB   = 3'd3;
    localparam logic [2:0] S_WR1   = 3'd4;
    localparam logic [2:0] S_WR2   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [IDX_W-1:0]    clr_reg, clr_next;
    logic [IDX_W-1:0]    free_reg, free_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;

    logic [ACTION_W-1:0] act_reg, act_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [IDX_W-1:0]    anchor_reg, anchor_next;
    logic [IDX_W-1:0]    after_reg, after_next;
    logic [IDX_W-1:0]    link_reg, link_next;
    logic [STATUS_W-1:0] stat_reg, stat_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [VALUE_W-1:0]  vout_reg, vout_next;

    logic [IDX_W-1:0]    s_idx;
    logic [IDX_W-1:0]    nxt_d;
    logic [IDX_W-1:0]    prv_d;
    logic                s_ok;
    logic                full;
    logic                empty;
    logic                unlink;
    logic                go_link;
    logic                do_set;
    logic [IDX_W-1:0]    anchor_c;
    logic [IDX_W-1:0]    after_c;

    assign s_idx  = IDX_W'(slot_reg);
    assign nxt_d  = rsp.nxt_rd_data[IDX_W-1:0];
    assign prv_d  = rsp.prv_rd_data[IDX_W-1:0];
    assign s_ok   = (32'(slot_reg) < 32'(SLOTS)) && rsp.used_rd_data;
    assign full   = (cnt_reg == LAST_SLOT);
    assign empty  = (cnt_reg == '0);
    assign unlink = is_unlink(act_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    assign res.status    = stat_reg;
    assign res.index_out = idx_reg;
    assign res.value_out = $signed(vout_reg);
    assign res.count     = COUNT_W'(cnt_reg);

    // Decode the request against the first read of the table
    always_comb
    begin
        stat_next = STAT_OK;
        idx_next  = '0;
        vout_next = '0;
        go_link   = 1'b0;
        do_set    = 1'b0;
        anchor_c  = '0;
        after_c   = '0;
        unique case (act_reg) inside
            ACT_PUSH_FRONT:
            begin
                after_c = nxt_d;
                if (full) stat_next = STAT_FULL;
                else      go_link   = 1'b1;
            end
            ACT_PUSH_BACK:
            begin
                anchor_c = prv_d;
                if (full) stat_next = STAT_FULL;
                else      go_link   = 1'b1;
            end
            ACT_POP_FRONT, ACT_POP_BACK:
            begin
                anchor_c = (act_reg == ACT_POP_FRONT) ? nxt_d : prv_d;
                if (empty) stat_next = STAT_EMPTY;
                else       go_link   = 1'b1;
            end
            ACT_INSERT_AFTER:
            begin
                anchor_c = s_idx;
                after_c  = nxt_d;
                if (!s_ok)     stat_next = STAT_RANGE;
                else if (full) stat_next = STAT_FULL;
                else           go_link   = 1'b1;
            end
            ACT_REMOVE, ACT_SET, ACT_GET:
            begin
                anchor_c = s_idx;
                if (!s_ok)                       stat_next = STAT_RANGE;
                else if (slot_reg == '0)         stat_next = STAT_HEAD;
                else if (act_reg == ACT_REMOVE)  go_link   = 1'b1;
                else if (act_reg == ACT_SET)     do_set    = 1'b1;
                else                             vout_next = rsp.elem_rd_data;
            end
            ACT_NEXT, ACT_PREV:
            begin
                if (!s_ok) stat_next = STAT_RANGE;
                else       idx_next  = SLOT_W'((act_reg == ACT_NEXT) ? nxt_d : prv_d);
            end
            ACT_FRONT, ACT_BACK:
            begin
                if (empty) stat_next = STAT_EMPTY;
                else       idx_next  = SLOT_W'((act_reg == ACT_FRONT) ? nxt_d : prv_d);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        free_next   = free_reg;
        cnt_next    = cnt_reg;
        act_next    = act_reg;
        slot_next   = slot_reg;
        val_next    = val_reg;
        anchor_next = anchor_reg;
        after_next  = after_reg;
        link_next   = link_reg;
        req         = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                req.nxt_wr_en    = 1'b1;
                req.nxt_wr_addr  = LINK_MAX_W'(clr_reg);
                req.nxt_wr_data  = ((clr_reg == '0) || (clr_reg == LAST_SLOT)) ?
                                   '0 : LINK_MAX_W'(clr_reg + 1'b1);
                req.prv_wr_en    = 1'b1;
                req.prv_wr_addr  = LINK_MAX_W'(clr_reg);
                req.used_wr_en   = 1'b1;
                req.used_wr_addr = LINK_MAX_W'(clr_reg);
                req.used_wr_data = (clr_reg == '0);
                if (clr_reg == LAST_SLOT) state_next = S_IDLE;
                else                      clr_next   = clr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = action;
                    slot_next  = slot_index;
                    val_next   = value_in;
                    state_next = S_RDA;
                end
            end
            S_RDA:
            begin
                req.rd_en        = 1'b1;
                req.nxt_rd_addr  = ((act_reg == ACT_INSERT_AFTER) || (act_reg == ACT_NEXT)) ?
                                   LINK_MAX_W'(s_idx) : '0;
                req.prv_rd_addr  = (act_reg == ACT_PREV) ? LINK_MAX_W'(s_idx) : '0;
                req.slot_rd_addr = LINK_MAX_W'(s_idx);
                state_next       = S_RDB;
            end
            S_RDB:
            begin
                anchor_next = anchor_c;
                after_next  = after_c;
                if (go_link)
                begin
                    // Chained read: links around the target, or the free list successor
                    req.rd_en        = 1'b1;
                    req.nxt_rd_addr  = LINK_MAX_W'(unlink ? anchor_c : free_reg);
                    req.prv_rd_addr  = LINK_MAX_W'(anchor_c);
                    req.slot_rd_addr = LINK_MAX_W'(anchor_c);
                    state_next       = S_WR1;
                end
                else
                begin
                    req.elem_wr_en   = do_set;
                    req.elem_wr_addr = LINK_MAX_W'(s_idx);
                    req.elem_wr_data = val_reg;
                    state_next       = S_DONE;
                end
            end
            S_WR1:
            begin
                if (unlink)
                begin
                    req.prv_wr_en    = 1'b1;
                    req.prv_wr_addr  = LINK_MAX_W'(nxt_d);
                    req.prv_wr_data  = LINK_MAX_W'(prv_d);
                    req.nxt_wr_en    = 1'b1;
                    req.nxt_wr_addr  = LINK_MAX_W'(prv_d);
                    req.nxt_wr_data  = LINK_MAX_W'(nxt_d);
                    req.used_wr_en   = 1'b1;
                    req.used_wr_addr = LINK_MAX_W'(anchor_reg);
                    req.used_wr_data = 1'b0;
                end
                else
                begin
                    req.nxt_wr_en    = 1'b1;
                    req.nxt_wr_addr  = LINK_MAX_W'(free_reg);
                    req.nxt_wr_data  = LINK_MAX_W'(after_reg);
                    req.prv_wr_en    = 1'b1;
                    req.prv_wr_addr  = LINK_MAX_W'(after_reg);
                    req.prv_wr_data  = LINK_MAX_W'(free_reg);
                    req.elem_wr_en   = 1'b1;
                    req.elem_wr_addr = LINK_MAX_W'(free_reg);
                    req.elem_wr_data = val_reg;
                    req.used_wr_en   = 1'b1;
                    req.used_wr_addr = LINK_MAX_W'(free_reg);
                    req.used_wr_data = 1'b1;
                    link_next        = nxt_d;
                end
                state_next = S_WR2;
            end
            S_WR2:
            begin
                req.nxt_wr_en   = 1'b1;
                req.nxt_wr_addr = LINK_MAX_W'(anchor_reg);
                req.nxt_wr_data = LINK_MAX_W'(free_reg);
                req.prv_wr_en   = 1'b1;
                if (unlink)
                begin
                    req.prv_wr_addr = LINK_MAX_W'(anchor_reg);
                    req.prv_wr_data = '0;
                    free_next       = anchor_reg;
                    cnt_next        = cnt_reg - 1'b1;
                end
                else
                begin
                    req.prv_wr_addr = LINK_MAX_W'(free_reg);
                    req.prv_wr_data = LINK_MAX_W'(anchor_reg);
                    free_next       = link_reg;
                    cnt_next        = cnt_reg + 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready) state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            free_reg  <= IDX_W'(1);
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            free_reg  <= free_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        slot_reg   <= slot_next;
        val_reg    <= val_next;
        anchor_reg <= anchor_next;
        after_reg  <= after_next;
        link_reg   <= link_next;
        if (state_reg == S_RDB)
        begin
            stat_reg <= stat_next;
            idx_reg  <= idx_next;
            vout_reg <= vout_next;
        end
    end

endmodule

[hw/rtl/array_linked_list_engine_top.sv]
// Top level of the array linked list engine: stream ports, sequencer, slot table, result register.
`timescale 1ns / 1ps

// A doubly linked list of 32-bit elements lives in a table of SLOTS slots; slot 0 is
// the sentinel (its next link is the front, its prev link the back) and a singly
// linked free list threaded through the next links hands out unused slots. Each
// request on the slave stream names one action in s_axis_tuser and returns exactly
// one result on the master stream: a status in m_axis_tuser, plus the returned slot,
// the element read by get and the element count after the action in m_axis_tdata.
// Any error leaves the list unchanged; a full table reports "list full" and does
// not grow. After reset the block runs a clearing pass that writes the link and
// used tables one slot per cycle, over all SLOTS slots, with s_axis_tready low. A
// request then goes S_RDA (first read), S_RDB (decode), S_DONE for front, back,
// next, prev, get, set, unused actions and every error; push, pop, insert and remove
// go S_RDA, S_RDB (chained link read), S_WR1, S_WR2 (link writes), S_DONE. This comes
// from the single read and single write port of each table memory: a structural
// change needs a first read, a chained link read whose address depends on it, and
// link writes in S_WR1 and S_WR2. One request is worked at a time; the result
// register lets the next request start while a result waits for m_axis_tready.
module array_linked_list_engine_top #(
    parameter int SLOTS = alle_pkg::SLOTS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] slot_index, [39:8] value_in
    input  logic [alle_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [3:0] action
    input  logic [alle_pkg::ACTION_W-1:0]       s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] index_out, [39:8] value_out, [47:40] count
    output logic [alle_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [2:0] status
    output logic [alle_pkg::STATUS_W-1:0]       m_axis_tuser
);
    import alle_pkg::*;

    tbl_req_t tbl_req;
    tbl_rsp_t tbl_rsp;
    res_t     seq_res;
    logic     seq_res_valid;
    logic     seq_res_ready;

    logic     m_valid_reg, m_valid_next;
    res_t     m_res_reg;

    // Hand a finished result to the output register whenever it is empty or draining
    assign seq_res_ready = !m_valid_reg || m_axis_tready;

    alle_seq #(
        .SLOTS (SLOTS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .action     (s_axis_tuser),
        .slot_index (s_axis_tdata[SLOT_W-1:0]),
        .value_in   ($signed(s_axis_tdata[SLOT_W+VALUE_W-1:SLOT_W])),
        .res_valid  (seq_res_valid),
        .res_ready  (seq_res_ready),
        .res        (seq_res),
        .req        (tbl_req),
        .rsp        (tbl_rsp)
    );

    alle_table #(
        .SLOTS (SLOTS)
    ) u_table (
        .clk (clk),
        .req (tbl_req),
        .rsp (tbl_rsp)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (seq_res_valid && seq_res_ready) m_valid_next = 1'b1;
        else if (m_axis_tready)             m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Load the result payload on the same condition that raises valid
    always_ff @(posedge clk)
    begin
        if (seq_res_valid && seq_res_ready)
        begin
            m_res_reg <= seq_res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_res_reg.status;
    assign m_axis_tdata  = OUT_TDATA_W'({m_res_reg.count, m_res_reg.value_out,
                                         m_res_reg.index_out});

endmodule

[hw/rtl/alle_checker.sv]
// Port-level checker for the array linked list engine and its bind to the top level.
`timescale 1ns / 1ps

module alle_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [alle_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input logic [alle_pkg::STATUS_W-1:0]       m_axis_tuser
);
    import alle_pkg::*;

    // An error result carries neither a slot nor an element
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != STAT_OK)) |->
        (m_axis_tdata[SLOT_W+VALUE_W-1:0] == '0))
        else $error("error result with nonzero index or value");

    // Work one request at a time: ready drops after an accepted request
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while another is in flight");

    // A result never appears in the cycle right after a request is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
        else $error("result raised too early after request");

    // Hold a stalled result
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed or dropped");

endmodule

bind array_linked_list_engine_top alle_checker u_alle_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
